// ----- hw/rtl/are_pkg.sv -----
package are_pkg;

   localparam logic [1:0] ACT_LOOKUP  = 2'd0;
   localparam logic [1:0] ACT_ARP     = 2'd1;
   localparam logic [1:0] ACT_RESOLVE = 2'd2;
   localparam logic [1:0] ACT_ADD     = 2'd3;

   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [15:0] OP_REPLY   = 16'd2;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_REPLY   = 3'd1;
   localparam logic [2:0] KIND_REQUEST = 3'd2;
   localparam logic [2:0] KIND_LOOKUP  = 3'd3;
   localparam logic [2:0] KIND_DROP    = 3'd4;

   localparam logic [2:0] REG_ACTIVE = 3'd0;
   localparam logic [2:0] REG_IP0    = 3'd1;
   localparam logic [2:0] REG_MAC0   = 3'd2;
   localparam logic [2:0] REG_IP1    = 3'd3;
   localparam logic [2:0] REG_MAC1   = 3'd4;

   localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
   localparam logic [5:0]  PFX_EXACT = 6'd1;
   localparam logic [5:0]  PFX_FULL  = 6'd32;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] arp_op;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
      logic        iface;
      logic [5:0]  prefix_len;
   } item_type;

   // classified command passed from front to back
   typedef struct packed {
      item_type    item;
      logic        drop;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        hit;
      logic [47:0] out_mac;
      logic [31:0] out_target_ip;
      logic        out_iface;
      logic [31:0] out_sender_ip;
      logic [47:0] out_sender_mac;
      logic        learned;
      logic        table_full;
      logic        pending_full;
      logic        pending_cleared;
   } result_type;

   function automatic logic [31:0] prefix_mask(input logic [5:0] p);
      logic [31:0] m;
      if (p == 6'd0) begin
         m = 32'd0;
      end else if (p >= PFX_FULL) begin
         m = '1;
      end else begin
         m = 32'hFFFF_FFFF << (6'd32 - p);
      end
      return m;
   endfunction

endpackage

// ----- hw/rtl/are_front.sv -----
module are_front
   import are_pkg::*;
#(
   parameter int NUM_IFACES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   input  logic [1:0]  active_ifaces,
   input  logic [31:0] ip0,
   input  logic [31:0] ip1,
   output logic        q_valid,
   input  logic        q_ready,
   output cmd_type     q_cmd
);

   logic [1:0]  n_act;
   logic        to_me;
   logic        drop;
   cmd_type     slot_ff [2];
   cmd_type     slot_in;
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   always_comb begin
      n_act = (active_ifaces > 2'(NUM_IFACES)) ? 2'(NUM_IFACES) : active_ifaces;
      to_me = ((n_act >= 2'd1) && (in_item.target_ip == ip0)) ||
              ((n_act >= 2'd2) && (in_item.target_ip == ip1));
      drop  = !to_me || ((in_item.arp_op != OP_REQUEST) &&
                         (in_item.arp_op != OP_REPLY));
      slot_in.item = in_item;
      slot_in.drop = (in_item.action == ACT_ARP) && drop;
   end

   // two entry queue
   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = slot_ff[rptr_ff];
   assign wptr_in  = wptr_ff ^ push;
   assign rptr_in  = rptr_ff ^ pop;
   assign cnt_in   = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= slot_in;
      end
   end

endmodule

// ----- hw/rtl/are_back.sv -----
module are_back
   import are_pkg::*;
#(
   parameter int TABLE_DEPTH   = 16,
   parameter int PENDING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  cmd_type     q_cmd,
   input  logic [31:0] ip0,
   input  logic [47:0] mac0,
   input  logic [31:0] ip1,
   input  logic [47:0] mac1,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  out_res
);

   localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int PCW = $clog2(PENDING_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TSCAN = 3'd1;
   localparam logic [2:0] ST_PSCAN = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [31:0] tip_mem  [TABLE_DEPTH];
   logic [47:0] tmac_mem [TABLE_DEPTH];
   logic [5:0]  tpfx_mem [TABLE_DEPTH];
   logic [31:0] pip_ff   [PENDING_DEPTH];
   logic        pifc_ff  [PENDING_DEPTH];
   logic [PENDING_DEPTH-1:0] pval_ff;

   logic [2:0]    st_ff;
   item_type      it_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] idx_ff;
   logic [PCW-1:0] pidx_ff;
   logic          rd_ok_ff;
   logic [31:0]   rd_ip_ff;
   logic [47:0]   rd_mac_ff;
   logic [5:0]    rd_pfx_ff;
   logic          found_ff, exact_ff;
   logic [5:0]    best_ff;
   logic [47:0]   fmac_ff;
   logic          pmatch_ff, pfree_ok_ff, pclr_ok_ff;
   logic [PW-1:0] pslot_ff, pclr_ff;
   result_type    res_ff;
   logic          ov_ff;

   logic [31:0] key, m;
   logic        tmatch;
   logic        tfull;

   assign q_ready   = (st_ff == ST_IDLE) && !ov_ff;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;
   assign key   = (it_ff.action == ACT_ARP) ? it_ff.sender_ip : it_ff.target_ip;
   assign m     = prefix_mask(rd_pfx_ff);
   assign tmatch = (key & m) == (rd_ip_ff & m);
   assign tfull = (cnt_ff >= CW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      result_type r;
      logic [5:0] pf;
      r = '0;
      pf = 6'd0;
      if (reset) begin
         st_ff   <= ST_IDLE;
         ov_ff   <= 1'b0;
         cnt_ff  <= '0;
         pval_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (q_valid && !ov_ff) begin
                  it_ff    <= q_cmd.item;
                  idx_ff   <= '0;
                  pidx_ff  <= '0;
                  found_ff <= 1'b0;
                  exact_ff <= 1'b0;
                  best_ff  <= 6'd0;
                  fmac_ff  <= '0;
                  pmatch_ff <= 1'b0;
                  pfree_ok_ff <= 1'b0;
                  pclr_ok_ff <= 1'b0;
                  rd_ok_ff <= 1'b0;
                  if (q_cmd.drop) begin
                     r.kind = KIND_DROP;
                     res_ff <= r;
                     ov_ff  <= 1'b1;
                  end else if (q_cmd.item.action == ACT_RESOLVE) begin
                     st_ff <= ST_PSCAN;
                  end else if (q_cmd.item.action == ACT_ADD) begin
                     st_ff <= ST_FIN;
                  end else begin
                     st_ff <= ST_TSCAN;
                  end
               end
            end
            ST_TSCAN: begin
               // read issue one entry a cycle, compare registered data
               if (rd_ok_ff && !exact_ff) begin
                  if (rd_pfx_ff == PFX_EXACT) begin
                     if (rd_ip_ff == key) begin
                        exact_ff <= 1'b1;
                        found_ff <= 1'b1;
                        fmac_ff  <= rd_mac_ff;
                     end
                  end else if (tmatch && rd_pfx_ff > best_ff) begin
                     best_ff  <= rd_pfx_ff;
                     found_ff <= 1'b1;
                     fmac_ff  <= rd_mac_ff;
                  end
               end
               if (idx_ff < cnt_ff) begin
                  rd_ip_ff  <= tip_mem[idx_ff[TW-1:0]];
                  rd_mac_ff <= tmac_mem[idx_ff[TW-1:0]];
                  rd_pfx_ff <= tpfx_mem[idx_ff[TW-1:0]];
                  rd_ok_ff  <= 1'b1;
                  idx_ff    <= idx_ff + 1'b1;
               end else begin
                  rd_ok_ff <= 1'b0;
                  if (!rd_ok_ff) begin
                     st_ff <= (it_ff.action == ACT_ARP &&
                               it_ff.arp_op == OP_REPLY) ? ST_PSCAN : ST_FIN;
                  end
               end
            end
            ST_PSCAN: begin
               if (pidx_ff < PCW'(PENDING_DEPTH)) begin
                  if (pval_ff[pidx_ff[PW-1:0]]) begin
                     if (pip_ff[pidx_ff[PW-1:0]] == key) begin
                        pmatch_ff <= 1'b1;
                        if (!pclr_ok_ff) begin
                           pclr_ok_ff <= 1'b1;
                           pclr_ff    <= pidx_ff[PW-1:0];
                        end
                     end
                  end else if (!pfree_ok_ff) begin
                     pfree_ok_ff <= 1'b1;
                     pslot_ff    <= pidx_ff[PW-1:0];
                  end
                  pidx_ff <= pidx_ff + 1'b1;
               end else begin
                  st_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               case (it_ff.action)
                  ACT_LOOKUP: begin
                     r.kind = KIND_LOOKUP;
                     r.hit  = found_ff;
                     r.out_mac = found_ff ? fmac_ff : '0;
                  end
                  ACT_ARP: begin
                     if (!found_ff) begin
                        if (!tfull) begin
                           tip_mem[cnt_ff[TW-1:0]]  <= it_ff.sender_ip;
                           tmac_mem[cnt_ff[TW-1:0]] <= it_ff.sender_mac;
                           tpfx_mem[cnt_ff[TW-1:0]] <= PFX_FULL;
                           cnt_ff <= cnt_ff + 1'b1;
                           r.learned = 1'b1;
                        end else begin
                           r.table_full = 1'b1;
                        end
                     end
                     if (it_ff.arp_op == OP_REQUEST) begin
                        r.kind = KIND_REPLY;
                        r.out_mac = it_ff.sender_mac;
                        r.out_target_ip = it_ff.sender_ip;
                        r.out_iface = it_ff.iface;
                        r.out_sender_ip = it_ff.iface ? ip1 : ip0;
                        r.out_sender_mac = it_ff.iface ? mac1 : mac0;
                     end else if (pclr_ok_ff) begin
                        pval_ff[pclr_ff] <= 1'b0;
                        r.pending_cleared = 1'b1;
                     end
                  end
                  ACT_RESOLVE: begin
                     if (pmatch_ff) begin
                        r.kind = KIND_NONE;
                     end else if (!pfree_ok_ff) begin
                        r.kind = KIND_DROP;
                        r.pending_full = 1'b1;
                     end else begin
                        pval_ff[pslot_ff]  <= 1'b1;
                        pip_ff[pslot_ff]   <= it_ff.target_ip;
                        pifc_ff[pslot_ff]  <= it_ff.iface;
                        r.kind = KIND_REQUEST;
                        r.out_mac = MAC_BCAST;
                        r.out_target_ip = it_ff.target_ip;
                        r.out_iface = it_ff.iface;
                        r.out_sender_ip = it_ff.iface ? ip1 : ip0;
                        r.out_sender_mac = it_ff.iface ? mac1 : mac0;
                     end
                  end
                  default: begin
                     pf = (it_ff.prefix_len > PFX_FULL) ? PFX_FULL : it_ff.prefix_len;
                     if (!tfull) begin
                        tip_mem[cnt_ff[TW-1:0]]  <= it_ff.target_ip;
                        tmac_mem[cnt_ff[TW-1:0]] <= it_ff.sender_mac;
                        tpfx_mem[cnt_ff[TW-1:0]] <= pf;
                        cnt_ff <= cnt_ff + 1'b1;
                        r.learned = 1'b1;
                     end else begin
                        r.kind = KIND_DROP;
                        r.table_full = 1'b1;
                     end
                  end
               endcase
               res_ff <= r;
               ov_ff  <= 1'b1;
               st_ff  <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/arp_resolver_engine.sv -----
// arp resolver engine: neighbor table lookups, arp request/reply handling,
// resolves and static adds.
// req_ channel: one beat per action; rsp_ channel: exactly one beat per
// action, in order. csr_ is an apb-style port for the interface addresses
// and the active interface count; the user must see that it is written
// only while the engine is idle, as the engine does not enforce this.
// the front stage checks whether a packet is addressed to us and holds a
// request or reply opcode, and pushes the beat into a two entry queue; the
// back stage runs one action at a time. a lookup or received packet scans
// the table one entry a cycle, a reply then scans the pending list one slot
// a cycle, a resolve scans only the pending list, an add goes straight to
// the finish state and a dropped packet is answered without a scan.
// reset empties the table and the pending list and the queue.
// when rsp_tready is low the result is held and the back stage waits;
// the front keeps taking up to two beats meanwhile.
module arp_resolver_engine
   import are_pkg::*;
#(
   parameter int TABLE_DEPTH   = 16,
   parameter int PENDING_DEPTH = 8,
   parameter int NUM_IFACES    = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action, arp_op, sender_ip, sender_mac, target_ip, iface, prefix_len
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // kind, hit, out_mac, out_target_ip, out_iface, out_sender_ip,
   // out_sender_mac, learned, table_full, pending_full, pending_cleared
   output logic [175:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   logic [1:0]  active_ff;
   logic [31:0] ip0_ff, ip1_ff;
   logic [47:0] mac0_ff, mac1_ff;
   logic [2:0]  reg_idx;
   item_type    item;
   logic        q_valid, q_ready;
   cmd_type     q_cmd;
   result_type  res;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[5:3];

   always_comb begin
      item.action     = req_tdata[1:0];
      item.arp_op     = req_tdata[17:2];
      item.sender_ip  = req_tdata[49:18];
      item.sender_mac = req_tdata[97:50];
      item.target_ip  = req_tdata[129:98];
      item.iface      = req_tdata[130];
      item.prefix_len = req_tdata[136:131];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 2'd1;
         ip0_ff    <= '0;
         ip1_ff    <= '0;
         mac0_ff   <= '0;
         mac1_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (reg_idx)
            REG_ACTIVE: active_ff <= csr_pwdata[1:0];
            REG_IP0:    ip0_ff    <= csr_pwdata[31:0];
            REG_MAC0:   mac0_ff   <= csr_pwdata[47:0];
            REG_IP1:    ip1_ff    <= csr_pwdata[31:0];
            REG_MAC1:   mac1_ff   <= csr_pwdata[47:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ACTIVE: csr_prdata = {62'd0, active_ff};
         REG_IP0:    csr_prdata = {32'd0, ip0_ff};
         REG_MAC0:   csr_prdata = {16'd0, mac0_ff};
         REG_IP1:    csr_prdata = {32'd0, ip1_ff};
         REG_MAC1:   csr_prdata = {16'd0, mac1_ff};
         default:    csr_prdata = 64'd0;
      endcase
   end

   are_front #(.NUM_IFACES(NUM_IFACES)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(item),
      .active_ifaces(active_ff), .ip0(ip0_ff), .ip1(ip1_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   are_back #(.TABLE_DEPTH(TABLE_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .ip0(ip0_ff), .mac0(mac0_ff), .ip1(ip1_ff), .mac1(mac1_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {7'd0, res.pending_cleared, res.pending_full, res.table_full,
                       res.learned, res.out_sender_mac, res.out_sender_ip,
                       res.out_iface, res.out_target_ip, res.out_mac, res.hit,
                       res.kind};

endmodule

// ----- test/arp_resolver_engine_tb.sv -----
`timescale 1ns / 100ps

module arp_resolver_engine_tb
   import are_pkg::*;
();

   localparam int TBL_DEPTH  = 16;
   localparam int PEND_DEPTH = 8;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // action, arp_op, sender_ip, sender_mac, target_ip, iface, prefix_len
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // kind, hit, out_mac, out_target_ip, out_iface, out_sender_ip,
   // out_sender_mac, learned, table_full, pending_full, pending_cleared
   logic [175:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [5:0]   csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   arp_resolver_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // model of the engine state
   logic [1:0]  cfg_active;
   logic [31:0] cfg_ip [2];
   logic [47:0] cfg_mac [2];
   logic [31:0] nbr_ip [TBL_DEPTH];
   logic [47:0] nbr_mac [TBL_DEPTH];
   logic [5:0]  nbr_pfx [TBL_DEPTH];
   int          nbr_count;
   logic [31:0] wait_ip [PEND_DEPTH];
   logic        wait_used [PEND_DEPTH];

   result_type  answer_q [$];
   int          errors;
   int          items_sent;
   int          results_seen;
   int          kind_seen [8];
   int          burst_left;
   bit          no_gaps;
   int          hold_left;
   logic [31:0] ip_pool [8];

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #5ms;
      $display("timeout: %0d results still outstanding", answer_q.size());
      $display("arp_resolver_engine_tb: done, errors");
      $finish;
   end

   function automatic logic [31:0] net_mask(input logic [5:0] p);
      if (p == 6'd0) return 32'd0;
      if (p >= 6'd32) return 32'hFFFF_FFFF;
      return ~(32'hFFFF_FFFF >> p);
   endfunction

   function automatic logic find_neighbor(input logic [31:0] ip, output logic [47:0] mac);
      int best;
      logic found;
      logic [31:0] m;
      best = 0;
      found = 1'b0;
      mac = '0;
      for (int i = 0; i < nbr_count; i++) begin
         if (nbr_pfx[i] == PFX_EXACT) begin
            if (nbr_ip[i] == ip) begin
               mac = nbr_mac[i];
               return 1'b1;
            end
         end else begin
            m = net_mask(nbr_pfx[i]);
            if ((ip & m) == (nbr_ip[i] & m) && int'(nbr_pfx[i]) > best) begin
               best = int'(nbr_pfx[i]);
               mac = nbr_mac[i];
               found = 1'b1;
            end
         end
      end
      return found;
   endfunction

   function automatic logic store_neighbor(input logic [31:0] ip, input logic [47:0] mac,
                                           input logic [5:0] p);
      if (nbr_count >= TBL_DEPTH) return 1'b0;
      nbr_ip[nbr_count] = ip;
      nbr_mac[nbr_count] = mac;
      nbr_pfx[nbr_count] = (p > PFX_FULL) ? PFX_FULL : p;
      nbr_count++;
      return 1'b1;
   endfunction

   function automatic void fill_frame(inout result_type r, input logic [2:0] k,
                                      input logic [47:0] mac, input logic [31:0] tip,
                                      input logic ifc);
      r.kind = k;
      r.out_mac = mac;
      r.out_target_ip = tip;
      r.out_iface = ifc;
      r.out_sender_ip = cfg_ip[ifc];
      r.out_sender_mac = cfg_mac[ifc];
   endfunction

   function automatic result_type resolve_action(input item_type it);
      result_type r;
      logic [47:0] mac;
      logic to_us;
      int n;
      int slot;
      r = '0;
      case (it.action)
         ACT_LOOKUP: begin
            r.kind = KIND_LOOKUP;
            r.hit = find_neighbor(it.target_ip, mac);
            r.out_mac = r.hit ? mac : 48'd0;
         end
         ACT_ARP: begin
            n = (cfg_active > 2) ? 2 : cfg_active;
            to_us = 1'b0;
            for (int i = 0; i < n; i++)
               if (it.target_ip == cfg_ip[i]) to_us = 1'b1;
            if (!to_us || (it.arp_op != OP_REQUEST && it.arp_op != OP_REPLY)) begin
               r.kind = KIND_DROP;
               return r;
            end
            if (!find_neighbor(it.sender_ip, mac)) begin
               if (store_neighbor(it.sender_ip, it.sender_mac, PFX_FULL)) r.learned = 1'b1;
               else r.table_full = 1'b1;
            end
            if (it.arp_op == OP_REQUEST) begin
               fill_frame(r, KIND_REPLY, it.sender_mac, it.sender_ip, it.iface);
            end else begin
               for (int i = 0; i < PEND_DEPTH; i++) begin
                  if (wait_used[i] && wait_ip[i] == it.sender_ip) begin
                     wait_used[i] = 1'b0;
                     r.pending_cleared = 1'b1;
                     break;
                  end
               end
            end
         end
         ACT_RESOLVE: begin
            slot = PEND_DEPTH;
            for (int i = 0; i < PEND_DEPTH; i++)
               if (wait_used[i] && wait_ip[i] == it.target_ip) return r;
            for (int i = PEND_DEPTH - 1; i >= 0; i--)
               if (!wait_used[i]) slot = i;
            if (slot == PEND_DEPTH) begin
               r.kind = KIND_DROP;
               r.pending_full = 1'b1;
               return r;
            end
            wait_used[slot] = 1'b1;
            wait_ip[slot] = it.target_ip;
            fill_frame(r, KIND_REQUEST, MAC_BCAST, it.target_ip, it.iface);
         end
         default: begin
            if (store_neighbor(it.target_ip, it.sender_mac, it.prefix_len)) begin
               r.learned = 1'b1;
            end else begin
               r.kind = KIND_DROP;
               r.table_full = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [47:0] rand_mac();
      logic [15:0] hi;
      hi = 16'($urandom_range(0, 65535));
      return {hi, $urandom()};
   endfunction

   function automatic item_type make_item(input logic [1:0] act, input logic [15:0] op,
                                          input logic [31:0] sip, input logic [47:0] smac,
                                          input logic [31:0] tip, input logic ifc,
                                          input logic [5:0] pfx);
      item_type it;
      it.action = act;
      it.arp_op = op;
      it.sender_ip = sip;
      it.sender_mac = smac;
      it.target_ip = tip;
      it.iface = ifc;
      it.prefix_len = pfx;
      return it;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("%0t: %s mismatch, got %0h, want %0h", $realtime, what, got, want);
   endtask

   task automatic send_item(input item_type it);
      if (!no_gaps && burst_left == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, it.prefix_len, it.iface, it.target_ip, it.sender_mac,
                    it.sender_ip, it.arp_op, it.action};
      do @(posedge clock); while (!req_tready);
      answer_q.push_back(resolve_action(it));
      items_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      // an action may still be finishing its scans
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ACTIVE: cfg_active = value[1:0];
         REG_IP0:    cfg_ip[0] = value[31:0];
         REG_MAC0:   cfg_mac[0] = value[47:0];
         REG_IP1:    cfg_ip[1] = value[31:0];
         default:    cfg_mac[1] = value[47:0];
      endcase
   endtask

   task automatic set_ifaces(input logic [1:0] n, input logic [31:0] ip0,
                             input logic [47:0] mac0, input logic [31:0] ip1,
                             input logic [47:0] mac1);
      csr_write(REG_ACTIVE, {62'd0, n});
      csr_write(REG_IP0, {32'd0, ip0});
      csr_write(REG_MAC0, {16'd0, mac0});
      csr_write(REG_IP1, {32'd0, ip1});
      csr_write(REG_MAC1, {16'd0, mac1});
   endtask

   // receiver: a long hold when asked, otherwise stretches that are either always ready or randomly stalled
   initial begin
      int run;
      bit stalling;
      rsp_tready = 1'b0;
      run = 0;
      stalling = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (run == 0) begin
               stalling = $urandom_range(0, 1);
               run = $urandom_range(20, 200);
            end
            run--;
            rsp_tready <= stalling ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tdata[2:0];
         got.hit = rsp_tdata[3];
         got.out_mac = rsp_tdata[51:4];
         got.out_target_ip = rsp_tdata[83:52];
         got.out_iface = rsp_tdata[84];
         got.out_sender_ip = rsp_tdata[116:85];
         got.out_sender_mac = rsp_tdata[164:117];
         got.learned = rsp_tdata[165];
         got.table_full = rsp_tdata[166];
         got.pending_full = rsp_tdata[167];
         got.pending_cleared = rsp_tdata[168];
         results_seen++;
         kind_seen[got.kind]++;
         if (answer_q.size() == 0) begin
            report("unexpected beat, kind", got.kind, 0);
         end else begin
            want = answer_q.pop_front();
            if (got.kind != want.kind) report("kind", got.kind, want.kind);
            if (got.hit != want.hit) report("hit", got.hit, want.hit);
            if (got.out_mac != want.out_mac) report("out_mac", got.out_mac, want.out_mac);
            if (got.out_target_ip != want.out_target_ip)
               report("out_target_ip", got.out_target_ip, want.out_target_ip);
            if (got.out_iface != want.out_iface)
               report("out_iface", got.out_iface, want.out_iface);
            if (got.out_sender_ip != want.out_sender_ip)
               report("out_sender_ip", got.out_sender_ip, want.out_sender_ip);
            if (got.out_sender_mac != want.out_sender_mac)
               report("out_sender_mac", got.out_sender_mac, want.out_sender_mac);
            if (got.learned != want.learned) report("learned", got.learned, want.learned);
            if (got.table_full != want.table_full)
               report("table_full", got.table_full, want.table_full);
            if (got.pending_full != want.pending_full)
               report("pending_full", got.pending_full, want.pending_full);
            if (got.pending_cleared != want.pending_cleared)
               report("pending_cleared", got.pending_cleared, want.pending_cleared);
         end
      end
   end

   task automatic test_table_and_arp();
      set_ifaces(2'd1, 32'h0A00_0001, 48'h0200_0000_0001, 32'h0A00_0101, 48'h0200_0000_0101);
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'h0A00_0002, 1'b0, 0));
      send_item(make_item(ACT_ADD, 0, 0, 48'h1111_2222_3333, 32'h0A00_0002, 1'b0, PFX_EXACT));
      send_item(make_item(ACT_ADD, 0, 0, 48'h4444_5555_6666, 32'h0A00_0000, 1'b0, 6'd24));
      send_item(make_item(ACT_ADD, 0, 0, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0000, 1'b1, 6'd16));
      send_item(make_item(ACT_ADD, 0, 0, 48'h0, 32'h0, 1'b0, 6'd0));
      // prefix above 32 is clamped
      send_item(make_item(ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 48'h7, 32'hFFFF_FFFF, 1'b1, 6'd63));
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'h0A00_0002, 1'b0, 0));
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'h0A00_0077, 1'b0, 0));
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'hC0A8_1234, 1'b0, 0));
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 1'b1, 0));
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'h0102_0304, 1'b0, 0));
      send_item(make_item(ACT_ARP, OP_REQUEST, 32'h0A00_0050, 48'hABCD_0000_0050,
                          32'h0A00_0001, 1'b0, 0));
      send_item(make_item(ACT_ARP, OP_REQUEST, 32'h0A00_0050, 48'hABCD_0000_0050,
                          32'h0A00_0001, 1'b1, 0));
      send_item(make_item(ACT_ARP, 16'd3, 32'h0A00_0051, 48'h1, 32'h0A00_0001, 1'b0, 0));
      // interface 1 not active yet
      send_item(make_item(ACT_ARP, OP_REQUEST, 32'h0A00_0052, 48'h2, 32'h0A00_0101, 1'b1, 0));
      // frame on an unused interface still uses its addresses
      send_item(make_item(ACT_RESOLVE, 0, 0, 0, 32'h0A00_0060, 1'b1, 0));
      send_item(make_item(ACT_RESOLVE, 0, 0, 0, 32'h0A00_0060, 1'b0, 0));
      send_item(make_item(ACT_ARP, OP_REPLY, 32'h0A00_0060, 48'h6060, 32'h0A00_0001, 1'b0, 0));
      send_item(make_item(ACT_ARP, OP_REPLY, 32'h0A00_0061, 48'h6161, 32'h0A00_0001, 1'b0, 0));
      send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'h0A00_0060, 1'b0, 0));
      drain();
   endtask

   task automatic test_full_lists();
      for (int i = 0; i < PEND_DEPTH + 1; i++)
         send_item(make_item(ACT_RESOLVE, 0, 0, 0, 32'h0A00_0200 + i, i[0], 0));
      // replies both clear pending entries and add table entries
      for (int i = 0; i < PEND_DEPTH; i++)
         send_item(make_item(ACT_ARP, OP_REPLY, 32'h0A00_0200 + i, rand_mac(),
                             32'h0A00_0001, 1'b0, 0));
      send_item(make_item(ACT_ARP, OP_REQUEST, 32'h0B00_0001, 48'h5, 32'h0A00_0001, 1'b1, 0));
      send_item(make_item(ACT_ADD, 0, 0, 48'h9, 32'h0B00_0002, 1'b0, 6'd8));
      drain();
   endtask

   task automatic test_backpressure();
      no_gaps = 1'b1;
      hold_left = 400;
      for (int i = 0; i < 12; i++)
         send_item(make_item(ACT_LOOKUP, 0, 0, 0, 32'h0A00_0000 + i, 1'b0, 0));
      no_gaps = 1'b0;
      drain();
   endtask

   task automatic random_phase(input int count);
      item_type it;
      int r;
      int sel;
      for (int i = 0; i < 8; i++)
         ip_pool[i] = ($urandom_range(0, 1) ? 32'h0A00_0000 : 32'hC0A8_0000) |
                      $urandom_range(0, 255);
      for (int n = 0; n < count; n++) begin
         it = make_item($urandom_range(0, 3), $urandom_range(0, 65535), $urandom(),
                        rand_mac(), $urandom(), $urandom_range(0, 1),
                        $urandom_range(0, 63));
         sel = $urandom_range(0, 9);
         if (sel < 6) it.sender_ip = ip_pool[$urandom_range(0, 7)];
         else if (sel < 8) it.sender_ip = ip_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 255);
         if ($urandom_range(0, 9) < 5) it.target_ip = ip_pool[$urandom_range(0, 7)];
         r = $urandom_range(0, 99);
         if (r < 40) begin
            it.action = ACT_ARP;
            if ($urandom_range(0, 9) != 0) it.target_ip = cfg_ip[$urandom_range(0, 1)];
            if ($urandom_range(0, 9) != 0)
               it.arp_op = $urandom_range(0, 1) ? OP_REQUEST : OP_REPLY;
         end else if (r < 60) begin
            it.action = ACT_RESOLVE;
         end else if (r < 85) begin
            it.action = ACT_LOOKUP;
         end else begin
            it.action = ACT_ADD;
         end
         send_item(it);
      end
      drain();
   endtask

   task automatic test_random();
      random_phase(350);
      set_ifaces(2'd2, $urandom(), rand_mac(), $urandom(), rand_mac());
      random_phase(350);
      set_ifaces(2'd3, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0, 48'h0);
      random_phase(300);
      set_ifaces(2'd0, $urandom(), rand_mac(), $urandom(), rand_mac());
      random_phase(150);
      set_ifaces(2'd2, 32'h0A00_0001, rand_mac(), 32'h0A00_0001, rand_mac());
      random_phase(300);
   endtask

   initial begin
      errors = 0;
      items_sent = 0;
      results_seen = 0;
      burst_left = 0;
      no_gaps = 1'b0;
      hold_left = 0;
      for (int i = 0; i < 8; i++) kind_seen[i] = 0;
      cfg_active = 2'd1;
      cfg_ip[0] = '0;
      cfg_ip[1] = '0;
      cfg_mac[0] = '0;
      cfg_mac[1] = '0;
      nbr_count = 0;
      for (int i = 0; i < PEND_DEPTH; i++) wait_used[i] = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_table_and_arp();
      test_full_lists();
      test_backpressure();
      test_random();

      $display("covered %0d actions: %0d lookups answered, %0d arp replies, %0d requests sent",
               items_sent, kind_seen[KIND_LOOKUP], kind_seen[KIND_REPLY],
               kind_seen[KIND_REQUEST]);
      $display("%0d dropped, %0d silent, %0d results checked, table ended with %0d entries",
               kind_seen[KIND_DROP], kind_seen[KIND_NONE], results_seen, nbr_count);
      if (errors == 0) begin
         $display("arp_resolver_engine_tb: done, clean");
      end else begin
         $display("arp_resolver_engine_tb: done, errors");
      end
      $finish;
   end

endmodule
